/* hw/rtl/ssd_pkg.sv */
// shared types, constants and glyph table for the seven-segment scan display
`default_nettype none

package ssd_pkg;

   // number of digits wired to the display, 2..8
   localparam int unsigned DIGIT_COUNT = 6;
   localparam int unsigned POS_W       = 3;
   localparam int unsigned SEG_W       = 8;
   localparam int unsigned SEL_W       = 8;
   localparam int unsigned VALUE_W     = 16;
   localparam int unsigned MODE_W      = 3;

   // logical digit slots written by the display modes
   localparam int unsigned SLOT_COUNT    = 6;
   localparam int unsigned POS_CNT_ONES  = 0;
   localparam int unsigned POS_CNT_TENS  = 1;
   localparam int unsigned POS_IR        = 2;
   localparam int unsigned POS_DIST_FRAC = 3;
   localparam int unsigned POS_DIST_ONES = 4;
   localparam int unsigned POS_DIST_TENS = 5;

   localparam logic [SEG_W-1:0] DP_BIT   = 8'h80;
   localparam logic [9:0]       DIST_MAX = 10'd999;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 3'd0,
      MODE_DIST  = 3'd1,
      MODE_COUNT = 3'd2,
      MODE_IR    = 3'd3,
      MODE_CLEAR = 3'd4,
      MODE_OFF   = 3'd5
   } ssd_mode_type;

   // buffer writes produced by one display command
   typedef struct packed {
      logic [SLOT_COUNT-1:0]            en;
      logic [SLOT_COUNT-1:0][SEG_W-1:0] pat;
   } ssd_wr_type;

   function automatic logic [SEG_W-1:0] glyph(input logic [3:0] d);
      logic [SEG_W-1:0] g;
      unique case (d)
         4'd0: g = 8'h3F;
         4'd1: g = 8'h06;
         4'd2: g = 8'h5B;
         4'd3: g = 8'h4F;
         4'd4: g = 8'h66;
         4'd5: g = 8'h6D;
         4'd6: g = 8'h7D;
         4'd7: g = 8'h07;
         4'd8: g = 8'h7F;
         4'd9: g = 8'h6F;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ssd_decode.sv */
// turns one display command into digit buffer writes
`default_nettype none

module ssd_decode (
   input  var ssd_pkg::ssd_mode_type     mode,
   input  var logic [15:0]               value,
   output var ssd_pkg::ssd_wr_type       wr
);
   import ssd_pkg::*;

   logic [9:0]  mm;
   logic [17:0] mm_x205;
   logic [15:0] mm_x41;
   logic [6:0]  mm_div10;
   logic [3:0]  mm_div100;
   logic [10:0] mm_div10_x10;
   logic [10:0] mm_frac;
   logic [7:0]  div100_x10;
   logic [6:0]  mm_ones;

   logic [31:0] val_xcccd;
   logic [12:0] val_div10;
   logic [16:0] val_div10_x10;
   logic [16:0] val_rem;

   // distance: clamp, then divide by 10 and 100 with reciprocal multiplies
   assign mm           = (value > 16'(DIST_MAX)) ? DIST_MAX : value[9:0];
   assign mm_x205      = 18'(mm) * 18'd205;
   assign mm_x41       = 16'(mm) * 16'd41;
   assign mm_div10     = mm_x205[17:11];
   assign mm_div100    = mm_x41[15:12];
   assign mm_div10_x10 = {1'b0, mm_div10, 3'b000} + {3'b000, mm_div10, 1'b0};
   assign mm_frac      = {1'b0, mm} - mm_div10_x10;
   assign div100_x10   = {1'b0, mm_div100, 3'b000} + {3'b000, mm_div100, 1'b0};
   assign mm_ones      = mm_div10 - div100_x10[6:0];

   // count: exact divide by 10 for any 16-bit value
   assign val_xcccd     = 32'(value) * 32'h0000_CCCD;
   assign val_div10     = val_xcccd[31:19];
   assign val_div10_x10 = {1'b0, val_div10, 3'b000} + {3'b000, val_div10, 1'b0};
   assign val_rem       = {1'b0, value} - val_div10_x10;

   always_comb begin
      wr.en  = '0;
      wr.pat = '0;
      unique case (mode)
         MODE_DIST: begin
            wr.en[POS_DIST_TENS]  = 1'b1;
            wr.en[POS_DIST_ONES]  = 1'b1;
            wr.en[POS_DIST_FRAC]  = 1'b1;
            wr.pat[POS_DIST_TENS] = (mm_div100 == 4'd0) ? 8'h00 : glyph(mm_div100);
            wr.pat[POS_DIST_ONES] = glyph(mm_ones[3:0]) | DP_BIT;
            wr.pat[POS_DIST_FRAC] = glyph(mm_frac[3:0]);
         end
         MODE_COUNT: begin
            // tens digit kept as is once the count passes 99
            wr.en[POS_CNT_TENS]  = (val_div10 <= 13'd9);
            wr.en[POS_CNT_ONES]  = 1'b1;
            wr.pat[POS_CNT_TENS] = (val_div10 == 13'd0) ? 8'h00 : glyph(val_div10[3:0]);
            wr.pat[POS_CNT_ONES] = glyph(val_rem[3:0]);
         end
         MODE_IR: begin
            wr.en[POS_IR]  = 1'b1;
            wr.pat[POS_IR] = (value > 16'd9) ? 8'h00 : glyph(value[3:0]);
         end
         default: begin
            wr.en  = '0;
            wr.pat = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/seven_segment_scan_display.sv */
// top level of the multiplexed seven-segment display driver
// Usage:
//   req channel carries one command per transfer: tuser holds the mode
//   (tick, distance, count, ir key, clear, off), tdata the 16-bit operand.
//   rsp channel returns one transfer per command: the segment latch and the
//   active-low digit enables as they stand after that command.
//   A command is held in the input register, then decoded and applied to the
//   digit buffer, scan position and latches; the same update loads the result
//   and raises rsp valid. One command per cycle is sustained while the
//   receiver takes each result; the latches double as the result register and
//   the decode path uses constant reciprocal multiplies.
//   When the receiver stalls, the result holds and the input register keeps
//   one more command, then req_tready drops until the result is taken.
//   Reset clears the buffer (all digits blank), scan position to digit 0,
//   segments off and no digit selected; no result is pending after reset.
`default_nettype none

module seven_segment_scan_display (
   input  var logic        clock,
   input  var logic        reset,
   input  var logic        req_tvalid,
   output var logic        req_tready,
   input  var logic [15:0] req_tdata,   // value[15:0]
   input  var logic [2:0]  req_tuser,   // mode[2:0]
   output var logic        rsp_tvalid,
   input  var logic        rsp_tready,
   output var logic [15:0] rsp_tdata    // segments[7:0], digit_select[15:8]
);
   import ssd_pkg::*;

   logic                    in_vld_ff;
   logic [MODE_W-1:0]       mode_ff;
   logic [VALUE_W-1:0]      value_ff;
   logic                    out_vld_ff;
   logic [SEG_W-1:0]        seg_ff, seg_in;
   logic [SEL_W-1:0]        sel_ff, sel_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [DIGIT_COUNT-1:0][SEG_W-1:0] buf_ff, buf_in;

   logic         out_free;
   logic         advance;
   ssd_mode_type mode;
   ssd_wr_type   wr;
   logic [POS_W-1:0] cur_pos;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {sel_ff, seg_ff};
   assign mode       = ssd_mode_type'(mode_ff);

   ssd_decode u_decode (
      .mode  (mode),
      .value (value_ff),
      .wr    (wr)
   );

   always_comb begin
      seg_in  = seg_ff;
      sel_in  = sel_ff;
      pos_in  = pos_ff;
      buf_in  = buf_ff;
      cur_pos = (32'(pos_ff) >= DIGIT_COUNT) ? '0 : pos_ff;
      unique case (mode)
         MODE_TICK: begin
            sel_in = ~(SEL_W'(1) << cur_pos);
            seg_in = buf_ff[cur_pos];
            pos_in = (32'(cur_pos) + 1 >= DIGIT_COUNT) ? '0 : cur_pos + POS_W'(1);
         end
         MODE_CLEAR: begin
            buf_in = '0;
         end
         MODE_OFF: begin
            seg_in = '0;
            sel_in = '1;
         end
         default: begin
            // slots beyond the wired digit count are dropped
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (i < DIGIT_COUNT && wr.en[i]) begin
                  buf_in[i] = wr.pat[i];
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         seg_ff     <= '0;
         sel_ff     <= '1;
         pos_ff     <= '0;
         buf_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
            seg_ff     <= seg_in;
            sel_ff     <= sel_in;
            pos_ff     <= pos_in;
            buf_ff     <= buf_in;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         mode_ff  <= req_tuser;
         value_ff <= req_tdata;
      end
   end

endmodule

`default_nettype wire
